FILE: rtl/des_ks_pkg.sv
// shared types, tables and bit functions of the des key schedule
package des_ks_pkg;

  localparam int KEY_W   = 64;
  localparam int CD_W    = 56;
  localparam int HALF_W  = 28;
  localparam int SK_W    = 48;
  localparam int RND_W   = 4;
  localparam int ROUNDS  = 16;

  localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);

  // rounds that rotate by one place; all others rotate by two
  localparam logic [RND_W-1:0] RND_ONE_A = 4'd0;
  localparam logic [RND_W-1:0] RND_ONE_B = 4'd1;
  localparam logic [RND_W-1:0] RND_ONE_C = 4'd8;
  localparam logic [RND_W-1:0] RND_ONE_D = 4'd15;

  typedef logic [7:0] tab_entry_t;

  localparam tab_entry_t PC1_TAB [CD_W] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  localparam tab_entry_t PC2_TAB [SK_W] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  // queue fill status seen by both sides
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // pc-1: pure wiring, bit 1 of the standard numbering is the msb
  function automatic logic [CD_W-1:0] pc1(input logic [KEY_W-1:0] k);
    logic [CD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CD_W; i++) begin
      r[CD_W-1-i] = k[KEY_W - int'(PC1_TAB[i])];
    end
    return r;
  endfunction

  // pc-2: pure wiring
  function automatic logic [SK_W-1:0] pc2(input logic [CD_W-1:0] cd);
    logic [SK_W-1:0] r;
    r = '0;
    for (int i = 0; i < SK_W; i++) begin
      r[SK_W-1-i] = cd[CD_W - int'(PC2_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic shift_two(input logic [RND_W-1:0] rnd);
    return (rnd != RND_ONE_A) && (rnd != RND_ONE_B) &&
           (rnd != RND_ONE_C) && (rnd != RND_ONE_D);
  endfunction

  // rotate both halves left by one or two places
  function automatic logic [CD_W-1:0] rot_cd(input logic [CD_W-1:0] cd, input logic two);
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    c = cd[CD_W-1:HALF_W];
    d = cd[HALF_W-1:0];
    if (two) begin
      return {c[HALF_W-3:0], c[HALF_W-1:HALF_W-2], d[HALF_W-3:0], d[HALF_W-1:HALF_W-2]};
    end
    return {c[HALF_W-2:0], c[HALF_W-1], d[HALF_W-2:0], d[HALF_W-1]};
  endfunction

endpackage

FILE: rtl/des_key_schedule_top.sv
// top level of the des key schedule: front, key queue and subkey back end
// One key word in gives sixteen subkey words out, in round order, one per clock
// while the output is not stalled; the back end does one rotate plus pc-2 per
// round and takes the next key from the queue once the current key's last round
// is done, so rounds of consecutive keys follow with no gap. The front applies
// pc-1 and holds one key; the queue holds up to QUEUE_DEPTH more, so a burst of
// QUEUE_DEPTH+2 keys is taken before key_stall rises. An empty block registers
// a key in the front and the queue before its first subkey. Parity bits are ignored.
module des_key_schedule_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  // key channel
  input  logic                            key_valid,
  output logic                            key_stall,
  input  logic [des_ks_pkg::KEY_W-1:0]    key,
  // subkey channel
  output logic                            sk_valid,
  input  logic                            sk_stall,
  output logic [des_ks_pkg::SK_W-1:0]     subkey,
  output logic [des_ks_pkg::RND_W-1:0]    round_index,
  output logic                            last
);

  des_ks_pkg::q_stat_t           q_stat;
  logic                          push;
  logic [des_ks_pkg::CD_W-1:0]   push_cd;
  logic                          pop;
  logic [des_ks_pkg::CD_W-1:0]   head_cd;

  // front: pc-1 into a one-word holding register
  des_ks_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key       (key),
    .q_stat    (q_stat),
    .push      (push),
    .push_cd   (push_cd)
  );

  // decouples key intake from the sixteen-round sequence
  des_ks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cd (push_cd),
    .pop     (pop),
    .head_cd (head_cd),
    .q_stat  (q_stat)
  );

  // back: round counter, c/d rotation and registered pc-2 output
  des_ks_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .head_cd     (head_cd),
    .pop         (pop),
    .sk_valid    (sk_valid),
    .sk_stall    (sk_stall),
    .subkey      (subkey),
    .round_index (round_index),
    .last        (last)
  );

endmodule

FILE: rtl/des_ks_front.sv
// front stage: takes a key word, applies pc-1 and hands the c/d pair to the queue
module des_ks_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            key_valid,
  output logic                            key_stall,
  input  logic [des_ks_pkg::KEY_W-1:0]    key,
  input  des_ks_pkg::q_stat_t             q_stat,
  output logic                            push,
  output logic [des_ks_pkg::CD_W-1:0]     push_cd
);

  logic                          fr_valid;
  logic [des_ks_pkg::CD_W-1:0]   fr_cd;

  assign push      = fr_valid && !q_stat.full;
  assign key_stall = fr_valid && q_stat.full;
  assign push_cd   = fr_cd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (key_valid && !key_stall) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && !key_stall) begin
      fr_cd <= des_ks_pkg::pc1(key);
    end
  end

endmodule

FILE: rtl/des_ks_queue.sv
// small fifo of permuted key halves between front and back
module des_ks_queue #(
  parameter int DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [des_ks_pkg::CD_W-1:0]     push_cd,
  input  logic                            pop,
  output logic [des_ks_pkg::CD_W-1:0]     head_cd,
  output des_ks_pkg::q_stat_t             q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [des_ks_pkg::CD_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;

  assign head_cd          = entries[rd_ptr];
  assign q_stat.not_empty = (count != '0);
  assign q_stat.full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cd;
    end
  end

endmodule

FILE: rtl/des_ks_back.sv
// back stage: rotates c/d once per word and drives the pc-2 subkey register
module des_ks_back (
  input  logic                            clk,
  input  logic                            rst,
  input  des_ks_pkg::q_stat_t             q_stat,
  input  logic [des_ks_pkg::CD_W-1:0]     head_cd,
  output logic                            pop,
  output logic                            sk_valid,
  input  logic                            sk_stall,
  output logic [des_ks_pkg::SK_W-1:0]     subkey,
  output logic [des_ks_pkg::RND_W-1:0]    round_index,
  output logic                            last
);

  logic                           active;
  logic [des_ks_pkg::CD_W-1:0]    cd;
  logic [des_ks_pkg::RND_W-1:0]   rnd;

  logic                           out_free;
  logic                           step;
  logic [des_ks_pkg::CD_W-1:0]    src_cd;
  logic [des_ks_pkg::RND_W-1:0]   src_rnd;
  logic [des_ks_pkg::CD_W-1:0]    cd_next;
  logic                           is_last;

  assign out_free = !sk_valid || !sk_stall;
  assign step     = out_free && (active || q_stat.not_empty);
  assign pop      = out_free && !active && q_stat.not_empty;
  assign src_cd   = active ? cd : head_cd;
  assign src_rnd  = active ? rnd : '0;
  assign cd_next  = des_ks_pkg::rot_cd(src_cd, des_ks_pkg::shift_two(src_rnd));
  assign is_last  = (src_rnd == des_ks_pkg::LAST_RND);

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      sk_valid <= 1'b0;
    end else begin
      if (out_free) begin
        sk_valid <= step;
      end
      if (step) begin
        active <= !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      cd          <= cd_next;
      rnd         <= src_rnd + 1'b1;
      subkey      <= des_ks_pkg::pc2(cd_next);
      round_index <= src_rnd;
      last        <= is_last;
    end
  end

endmodule

FILE: rtl/des_ks_check.sv
// port-level checks of the des key schedule, bound to the top level
module des_ks_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            key_valid,
  input logic                            key_stall,
  input logic [des_ks_pkg::KEY_W-1:0]    key,
  input logic                            sk_valid,
  input logic                            sk_stall,
  input logic [des_ks_pkg::SK_W-1:0]     subkey,
  input logic [des_ks_pkg::RND_W-1:0]    round_index,
  input logic                            last
);

  // stalled key word holds
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key))
    else $error("stalled key word changed");

  // stalled subkey word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    sk_valid && sk_stall |=> sk_valid && $stable(subkey) && $stable(round_index)
                              && $stable(last))
    else $error("stalled subkey word changed");

  // last flag marks round 15 exactly
  a_last: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> (last == (round_index == des_ks_pkg::LAST_RND)))
    else $error("last flag does not match round index");

  // rounds of one key count up by one
  a_count: assert property (@(posedge clk) disable iff (rst)
    sk_valid && !sk_stall && !last ##1 sk_valid |->
      round_index == des_ks_pkg::RND_W'($past(round_index) + 1'b1))
    else $error("round index skipped");

  // a new key starts at round 0
  a_start: assert property (@(posedge clk) disable iff (rst)
    sk_valid && !sk_stall && last ##1 sk_valid |-> round_index == '0)
    else $error("key run did not start at round 0");

endmodule

bind des_key_schedule_top des_ks_check u_check (.*);
